/* hw/rtl/sha1md_pkg.sv */
// Shared types, constants and round functions for the SHA-1 digest block.
`timescale 1ns / 1ps
package sha1md_pkg;

  localparam int WordW     = 32;
  localparam int NumHash   = 5;
  localparam int SchedLen  = 16;
  localparam int CountW    = 61;
  localparam int PosW      = 6;
  localparam int RndW      = 7;
  localparam int IdxW      = 3;
  localparam int LenW      = 64;

  localparam logic [RndW-1:0] LastRound  = 7'd79;
  localparam logic [RndW-1:0] ExpandFrom = 7'd16;
  localparam logic [RndW-1:0] Phase1End  = 7'd20;
  localparam logic [RndW-1:0] Phase2End  = 7'd40;
  localparam logic [RndW-1:0] Phase3End  = 7'd60;

  localparam logic [PosW-1:0] LenPos  = 6'd56;
  localparam logic [PosW-1:0] LastPos = 6'd63;
  localparam logic [IdxW-1:0] LastIdx = 3'd4;
  localparam logic [7:0]      PadByte = 8'h80;

  // Index 0 is H0.
  localparam logic [NumHash-1:0][WordW-1:0] HInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  typedef logic [NumHash-1:0][WordW-1:0] sha1md_hash_t;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha1md_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1md_out_t;

  // Control into the message schedule line.
  typedef struct packed {
    logic            push;
    logic [7:0]      data;
    logic            word_done;
    logic            step;
    logic            expand;
  } sha1md_sctl_t;

  // Control into the round unit.
  typedef struct packed {
    logic            load;
    logic            step;
    logic [RndW-1:0] rnd;
  } sha1md_rctl_t;

  function automatic logic [WordW-1:0] round_k(input logic [RndW-1:0] rnd);
    logic [WordW-1:0] k;
    priority if (rnd < Phase1End) k = K0;
    else if (rnd < Phase2End)     k = K1;
    else if (rnd < Phase3End)     k = K2;
    else                          k = K3;
    return k;
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [RndW-1:0] rnd,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    priority if (rnd < Phase1End) f = (b & c) | (~b & d);
    else if (rnd < Phase2End)     f = b ^ c ^ d;
    else if (rnd < Phase3End)     f = (b & c) | (b & d) | (c & d);
    else                          f = b ^ c ^ d;
    return f;
  endfunction

endpackage

/* hw/rtl/sha1md_sched.sv */
// Message schedule: byte packing into a 16-word shift line and word expansion.
`timescale 1ns / 1ps
module sha1md_sched import sha1md_pkg::*; (
  input  logic             clk,
  input  sha1md_sctl_t     ctl,
  output logic [WordW-1:0] w_o
);

  logic [SchedLen-1:0][WordW-1:0] line_r;
  logic [23:0]                    acc_r;
  logic [WordW-1:0]               mix;

  // Oldest word sits at index 0; new words enter at the top.
  assign mix = line_r[13] ^ line_r[8] ^ line_r[2] ^ line_r[0];
  assign w_o = ctl.expand ? {mix[WordW-2:0], mix[WordW-1]} : line_r[0];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      if (ctl.word_done) begin
        line_r <= {{acc_r, ctl.data}, line_r[SchedLen-1:1]};
      end else begin
        acc_r <= {acc_r[15:0], ctl.data};
      end
    end else if (ctl.step) begin
      line_r <= {w_o, line_r[SchedLen-1:1]};
    end
  end

endmodule

/* hw/rtl/sha1md_round.sv */
// SHA-1 round unit: working registers A..E and one round per step.
`timescale 1ns / 1ps
module sha1md_round import sha1md_pkg::*; (
  input  logic             clk,
  input  sha1md_rctl_t     ctl,
  input  sha1md_hash_t     hash_i,
  input  logic [WordW-1:0] w_i,
  output sha1md_hash_t     work_o
);

  sha1md_hash_t     work_r;
  logic [WordW-1:0] a, b, c, d, e, tmp;

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  assign tmp = {a[WordW-6:0], a[WordW-1:WordW-5]} + round_f(ctl.rnd, b, c, d)
             + e + w_i + round_k(ctl.rnd);

  assign work_o = work_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work_r <= hash_i;
    end else if (ctl.step) begin
      work_r <= {d, c, {b[1:0], b[WordW-1:2]}, a, tmp};
    end
  end

endmodule

/* hw/rtl/sha1_message_digest.sv */
// SHA-1 message digest top level: byte intake, padding sequencer, digest output.
// Intake: byte beats are taken only while idle; a full 64-byte block then holds intake
//   for the compression (80 rounds on the shared round unit plus one hash update step).
// Closing a message pushes the 0x80 mark, zero bytes and the 8 length bytes,
//   runs one or two compressions, then gives five output beats, one per cycle
//   while out_stall is low; no new bytes are taken while the single round unit works.
// Reset: rst_n low (synchronous) returns to idle with H0..H4 loaded and count zero.
`timescale 1ns / 1ps
module sha1_message_digest import sha1md_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  sha1md_in_t  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output sha1md_out_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t              state_r;
  logic [PosW-1:0]     pos_r;        // byte slot in the current block
  logic [CountW-1:0]   cnt_r;        // message bytes so far
  logic [CountW-1:0]   cnt_nxt;
  logic [RndW-1:0]     rnd_r;
  logic [LenW-1:0]     len_r;        // bit length, shifted out a byte at a time
  logic                mark_r;       // 0x80 still to insert
  logic                pad_r;        // message is being closed
  logic                len_act_r;    // length bytes under way
  logic                final_r;      // length block is in the round unit
  logic [IdxW-1:0]     idx_r;
  logic                out_valid_r;
  sha1md_out_t         out_data_r;
  sha1md_hash_t        hash_r;
  sha1md_hash_t        work;

  logic                accept;
  logic                push;
  logic                len_sel;
  logic [7:0]          push_data;
  logic                out_free;
  logic [WordW-1:0]    w;
  sha1md_sctl_t        sctl;
  sha1md_rctl_t        rctl;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Count including the byte carried by the current beat.
  assign cnt_nxt = cnt_r + {{(CountW-1){1'b0}}, in_data.has_byte};

  // Padding byte choice: 0x80 first, then zeros, then the length from slot 56.
  assign len_sel = !mark_r && (len_act_r || pos_r == LenPos);

  always_comb begin
    push      = 1'b0;
    push_data = in_data.message_byte;
    if (state_r == ST_IDLE) begin
      push = accept && in_data.has_byte;
    end else if (state_r == ST_PAD) begin
      push = 1'b1;
      if (mark_r) begin
        push_data = PadByte;
      end else if (len_sel) begin
        push_data = len_r[LenW-1:LenW-8];
      end else begin
        push_data = 8'h00;
      end
    end
  end

  // Schedule line gets bytes while filling and shifts once per round.
  assign sctl.push      = push;
  assign sctl.data      = push_data;
  assign sctl.word_done = (pos_r[1:0] == 2'b11);
  assign sctl.step      = (state_r == ST_ROUND);
  assign sctl.expand    = (rnd_r >= ExpandFrom);

  // Load A..E from the hash as the last byte of a block lands.
  assign rctl.load = push && (pos_r == LastPos);
  assign rctl.step = (state_r == ST_ROUND);
  assign rctl.rnd  = rnd_r;

  sha1md_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .w_o (w)
  );

  sha1md_round u_round (
    .clk    (clk),
    .ctl    (rctl),
    .hash_i (hash_r),
    .w_i    (w),
    .work_o (work)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      rnd_r       <= '0;
      len_r       <= '0;
      mark_r      <= 1'b0;
      pad_r       <= 1'b0;
      len_act_r   <= 1'b0;
      final_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      hash_r      <= HInit;
    end else begin
      // Drop the output beat once taken; in ST_OUT the next load takes its place.
      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (push) begin
        pos_r <= pos_r + 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cnt_r <= cnt_nxt;
            if (in_data.end_of_message) begin
              mark_r <= 1'b1;
              pad_r  <= 1'b1;
              len_r  <= {cnt_nxt, 3'b000};
            end
            if (in_data.has_byte && pos_r == LastPos) begin
              state_r <= ST_ROUND;
            end else if (in_data.end_of_message) begin
              state_r <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (mark_r) begin
            mark_r <= 1'b0;
          end
          if (len_sel) begin
            len_act_r <= 1'b1;
            len_r     <= {len_r[LenW-9:0], 8'h00};
          end
          if (pos_r == LastPos) begin
            state_r <= ST_ROUND;
            final_r <= len_sel;
          end
        end
        ST_ROUND: begin
          if (rnd_r == LastRound) begin
            rnd_r   <= '0;
            state_r <= ST_ADD;
          end else begin
            rnd_r <= rnd_r + 1'b1;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < NumHash; i++) begin
            hash_r[i] <= hash_r[i] + work[i];
          end
          idx_r <= '0;
          if (final_r) begin
            state_r <= ST_OUT;
          end else if (pad_r) begin
            state_r <= ST_PAD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.digest_word <= hash_r[idx_r];
            out_data_r.word_index  <= idx_r;
            out_data_r.last_word   <= (idx_r == LastIdx);
            if (idx_r == LastIdx) begin
              // Clear for the next message; the last beat is already captured.
              state_r   <= ST_IDLE;
              hash_r    <= HInit;
              cnt_r     <= '0;
              pad_r     <= 1'b0;
              len_act_r <= 1'b0;
              final_r   <= 1'b0;
              idx_r     <= '0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A byte that fills slot 63 must start a compression on the next cycle.
  a_block_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.has_byte && pos_r == LastPos) |=> (state_r == ST_ROUND))
    else $error("full block did not enter the round loop");

  // Round counter stays within the 80 rounds.
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rnd_r <= LastRound))
    else $error("round counter out of range");

  // Digest output starts only after the length block's compression.
  a_out_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_OUT) |-> $past(state_r == ST_ADD && final_r))
    else $error("digest output entered without final compression");

  // Block slot returns to zero whenever a message closes.
  a_pos_clear_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (pos_r == '0))
    else $error("block slot not empty at digest output");

endmodule
